// File: rtl/tlpte_pkg.sv
// ----------------------------------------------------------------------------
// tlpte_pkg: shared types and constants of the two-level page table engine
// Field widths, entry bit positions, operation and status codes, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tlpte_pkg;

    localparam int DIR_INDEX_BITS   = 4;
    localparam int TABLE_INDEX_BITS = 10;
    localparam int OFS_BITS         = 12;
    localparam int FRAME_BITS       = 20;
    localparam int VA_BITS          = DIR_INDEX_BITS + TABLE_INDEX_BITS + OFS_BITS;
    localparam int SLOT_BITS        = DIR_INDEX_BITS + TABLE_INDEX_BITS;
    localparam int DIR_COUNT        = 1 << DIR_INDEX_BITS;
    localparam int SLOT_COUNT       = 1 << SLOT_BITS;
    localparam int ENTRY_BITS       = 32;

    // x86 entry bits
    localparam int BIT_P   = 0;
    localparam int BIT_RW  = 1;
    localparam int BIT_US  = 2;
    localparam int BIT_PCD = 4;

    typedef enum logic [2:0] {
        FN_INSTALL = 3'd0,
        FN_CHECK   = 3'd1,
        FN_XLATE   = 3'd2,
        FN_MAP     = 3'd3,
        FN_REMAP   = 3'd4,
        FN_UNMAP   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FAULT = 2'd1,
        ST_PERM  = 2'd2
    } status_t;

    typedef struct packed {
        logic load;        // accept request, latch fields, read table entry
        logic clear_step;  // zero one table entry of the selected directory slot
        logic commit;      // write back, update directory, load result register
    } cmd_t;

    typedef struct packed {
        logic in_install;  // request at the input port is an install
        logic clear_last;  // clear sweep is at its final entry
        logic out_free;    // result register can take a new result
    } stat_t;

endpackage

// File: rtl/tlpte_ctrl.sv
// ----------------------------------------------------------------------------
// tlpte_ctrl: sequencing of one request
// Accept, optional table clear sweep, then commit when the result slot frees.
// ----------------------------------------------------------------------------
module tlpte_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tlpte_pkg::stat_t stat,
    output tlpte_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.commit     = 1'b0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_install ? S_CLEAR : S_EXEC;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/tlpte_dpath.sv
// ----------------------------------------------------------------------------
// tlpte_dpath: page directory, page table memory and result logic
// Directory in flops, tables in a single-port memory, one result register.
// ----------------------------------------------------------------------------
module tlpte_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  tlpte_pkg::cmd_t                     cmd,
    output tlpte_pkg::stat_t                    stat,
    input  logic [2:0]                          func,
    input  logic [tlpte_pkg::VA_BITS-1:0]       virt_addr,
    input  logic [tlpte_pkg::FRAME_BITS-1:0]    phys_frame,
    input  logic                                prot_read,
    input  logic                                prot_write,
    input  logic                                no_cache,
    input  logic                                user_mode,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [31:0]                         phys_addr,
    output logic                                flush_needed
);

    localparam int DB = tlpte_pkg::DIR_INDEX_BITS;
    localparam int TB = tlpte_pkg::TABLE_INDEX_BITS;
    localparam int OB = tlpte_pkg::OFS_BITS;
    localparam int FB = tlpte_pkg::FRAME_BITS;
    localparam int EB = tlpte_pkg::ENTRY_BITS;
    localparam int SB = tlpte_pkg::SLOT_BITS;
    localparam int VA_TOP = tlpte_pkg::VA_BITS - 1;

    // latched request
    logic [2:0]              func_reg;
    logic [DB-1:0]           dir_idx_reg;
    logic [TB-1:0]           tbl_idx_reg;
    logic [OB-1:0]           ofs_reg;
    logic [FB-1:0]           frame_reg;
    logic                    rd_reg;
    logic                    wr_reg;
    logic                    nc_reg;
    logic                    usr_reg;

    logic [EB-1:0]           dir_reg [tlpte_pkg::DIR_COUNT];
    logic [EB-1:0]           tbl_mem [tlpte_pkg::SLOT_COUNT];
    logic [EB-1:0]           te_reg;
    logic [TB-1:0]           clr_cnt_reg;

    logic                    out_valid_reg;
    logic [1:0]              status_reg;
    logic [31:0]             phys_addr_reg;
    logic                    flush_reg;

    logic [EB-1:0]           de;
    logic                    dp;
    logic                    tp;
    logic [1:0]              res_status;
    logic [31:0]             res_pa;
    logic                    res_flush;
    logic                    te_write;
    logic [EB-1:0]           te_new;
    logic [EB-1:0]           prot_bits;
    logic                    mem_we;
    logic [SB-1:0]           mem_waddr;
    logic [EB-1:0]           mem_wdata;

    function automatic logic [EB-1:0] prot_bits_dir();
        logic [EB-1:0] b;
        b                    = '0;
        b[tlpte_pkg::BIT_P]  = 1'b1;
        b[tlpte_pkg::BIT_RW] = 1'b1;
        b[tlpte_pkg::BIT_US] = 1'b1;
        return b;
    endfunction

    assign stat.in_install = (func == tlpte_pkg::FN_INSTALL);
    assign stat.clear_last = (clr_cnt_reg == {TB{1'b1}});
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign de = dir_reg[dir_idx_reg];
    assign dp = de[tlpte_pkg::BIT_P];
    assign tp = te_reg[tlpte_pkg::BIT_P];

    always_comb
    begin
        prot_bits                     = '0;
        prot_bits[tlpte_pkg::BIT_P]   = 1'b1;
        prot_bits[tlpte_pkg::BIT_RW]  = wr_reg;
        prot_bits[tlpte_pkg::BIT_PCD] = nc_reg;
        prot_bits[tlpte_pkg::BIT_US]  = usr_reg;
    end

    always_comb
    begin
        res_status = tlpte_pkg::ST_OK;
        res_pa     = '0;
        res_flush  = 1'b0;
        te_write   = 1'b0;
        te_new     = '0;
        unique case (func_reg)
            tlpte_pkg::FN_INSTALL:
            begin
                res_flush = 1'b1;
            end
            tlpte_pkg::FN_CHECK:
            begin
                if (!dp)
                    res_status = tlpte_pkg::ST_FAULT;
                else if ((!de[tlpte_pkg::BIT_RW] && wr_reg) ||
                         (!de[tlpte_pkg::BIT_US] && usr_reg))
                    res_status = tlpte_pkg::ST_PERM;
                else if (!tp)
                    res_status = tlpte_pkg::ST_FAULT;
                else if ((!te_reg[tlpte_pkg::BIT_RW] && wr_reg) ||
                         (!te_reg[tlpte_pkg::BIT_US] && usr_reg))
                    res_status = tlpte_pkg::ST_PERM;
                else
                    res_pa = {te_reg[EB-1:OB], {OB{1'b0}}};
            end
            tlpte_pkg::FN_XLATE:
            begin
                if (!dp || !tp)
                    res_status = tlpte_pkg::ST_FAULT;
                else
                    res_pa = {te_reg[EB-1:OB], ofs_reg};
            end
            tlpte_pkg::FN_MAP:
            begin
                if (!rd_reg)
                    res_status = tlpte_pkg::ST_PERM;
                else if (!dp)
                    res_status = tlpte_pkg::ST_FAULT;
                else
                begin
                    te_write  = 1'b1;
                    te_new    = {frame_reg, {OB{1'b0}}} | prot_bits;
                    res_flush = tp && ((te_reg[tlpte_pkg::BIT_RW] && !wr_reg) ||
                                       (te_reg[tlpte_pkg::BIT_US] && !usr_reg) ||
                                       (te_reg[EB-1:OB] != frame_reg));
                end
            end
            tlpte_pkg::FN_REMAP:
            begin
                if (!rd_reg)
                    res_status = tlpte_pkg::ST_PERM;
                else if (!dp || !tp)
                    res_status = tlpte_pkg::ST_FAULT;
                else
                begin
                    te_write  = 1'b1;
                    te_new    = {te_reg[EB-1:OB], {OB{1'b0}}} | prot_bits;
                    res_flush = (te_reg[tlpte_pkg::BIT_RW] && !wr_reg) ||
                                (te_reg[tlpte_pkg::BIT_US] && !usr_reg);
                end
            end
            tlpte_pkg::FN_UNMAP:
            begin
                if (!dp || !tp)
                    res_status = tlpte_pkg::ST_FAULT;
                else
                begin
                    te_write  = 1'b1;
                    res_flush = 1'b1;
                end
            end
            default:
            begin
                res_status = tlpte_pkg::ST_PERM;
            end
        endcase
    end

    // single write port: clear sweep or write-back
    assign mem_we    = cmd.clear_step || (cmd.commit && te_write);
    assign mem_waddr = cmd.clear_step ? {dir_idx_reg, clr_cnt_reg}
                                      : {dir_idx_reg, tbl_idx_reg};
    assign mem_wdata = cmd.clear_step ? '0 : te_new;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            te_reg <= tbl_mem[virt_addr[VA_TOP:OB]];
        end
        if (mem_we)
        begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            dir_idx_reg <= virt_addr[VA_TOP:OB+TB];
            tbl_idx_reg <= virt_addr[OB+TB-1:OB];
            ofs_reg     <= virt_addr[OB-1:0];
            frame_reg   <= phys_frame;
            rd_reg      <= prot_read;
            wr_reg      <= prot_write;
            nc_reg      <= no_cache;
            usr_reg     <= user_mode;
        end
        if (cmd.commit)
        begin
            status_reg    <= res_status;
            phys_addr_reg <= res_pa;
            flush_reg     <= res_flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < tlpte_pkg::DIR_COUNT; i++)
            begin
                dir_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
                clr_cnt_reg <= '0;
            else if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;

            if (cmd.commit && (func_reg == tlpte_pkg::FN_INSTALL))
            begin
                dir_reg[dir_idx_reg] <= {frame_reg, {OB{1'b0}}} | prot_bits_dir();
            end

            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign phys_addr    = phys_addr_reg;
    assign flush_needed = flush_reg;

endmodule

// File: rtl/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine: x86-32 style two-level page table walker
// Holds a page directory and its page tables; one operation per request.
// ----------------------------------------------------------------------------
// Sequence: accept latches the request and reads its table entry; install
//   then zeroes all 2^TABLE_INDEX_BITS entries of its table; commit loads the result.
// Throughput: a new request is taken only once the last one has committed,
//   so requests never overlap; a result left unread stalls the commit and so the input.
// Reset: directory entries cleared to not present, result slot empty. Table
//   memory is not cleared; its entries are only used under a present directory entry,
//   and install zeroes that entry's whole table first.
// ----------------------------------------------------------------------------
module two_level_page_table_engine
(
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        func,
    input  logic [tlpte_pkg::VA_BITS-1:0]     virt_addr,
    input  logic [tlpte_pkg::FRAME_BITS-1:0]  phys_frame,
    input  logic                              prot_read,
    input  logic                              prot_write,
    input  logic                              no_cache,
    input  logic                              user_mode,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [31:0]                       phys_addr,
    output logic                              flush_needed
);

    // command bundle from the controller, status bundle back from the datapath
    tlpte_pkg::cmd_t  cmd;
    tlpte_pkg::stat_t stat;

    // Controller: idle -> (clear sweep on install) -> exec, where the commit
    // waits until the result register is free; a new request is still taken
    // while a result sits unread, and then waits in exec until it is read.
    tlpte_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: directory flops, table memory, permission checks, write-back
    // and the result register.
    tlpte_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (func),
        .virt_addr    (virt_addr),
        .phys_frame   (phys_frame),
        .prot_read    (prot_read),
        .prot_write   (prot_write),
        .no_cache     (no_cache),
        .user_mode    (user_mode),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .phys_addr    (phys_addr),
        .flush_needed (flush_needed)
    );

endmodule
